@@ design/trivium_stream_cipher_macros.svh @@
`ifndef TRIVIUM_STREAM_CIPHER_MACROS_SVH
`define TRIVIUM_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication on clock, disabled during reset.
`define TRV_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on clock, disabled during reset.
`define TRV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (ante) |=> (cons)) else $error(msg);

`endif

@@ design/trv_pkg.sv @@
package trv_pkg;

   localparam int LEN_A = 93;
   localparam int LEN_B = 84;
   localparam int LEN_C = 111;
   localparam int KEY_BITS = 80;
   localparam int ROUNDS_PER_BYTE = 8;

   localparam logic KIND_INIT = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   localparam logic [1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [1:0] CSR_IV_LOW   = 2'd2;
   localparam logic [1:0] CSR_IV_HIGH  = 2'd3;

   typedef struct packed {
      logic [LEN_A-1:0] a;
      logic [LEN_B-1:0] b;
      logic [LEN_C-1:0] c;
   } state_type;

   typedef struct packed {
      logic load;
      logic step8;
      logic step1;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_valid;
   } sts_type;

   function automatic logic trv_z(input state_type s);
      return s.a[65] ^ s.a[92] ^ s.b[68] ^ s.b[83] ^ s.c[65] ^ s.c[110];
   endfunction

   function automatic state_type trv_round(input state_type s);
      logic ta;
      logic tb;
      logic tc;
      logic fa;
      logic fb;
      logic fc;
      state_type n;
      ta = s.a[65] ^ s.a[92];
      tb = s.b[68] ^ s.b[83];
      tc = s.c[65] ^ s.c[110];
      fa = ta ^ (s.a[90] & s.a[91]);
      fb = tb ^ (s.b[81] & s.b[82]);
      fc = tc ^ (s.c[108] & s.c[109]);
      n.a = {s.a[LEN_A-2:0], fc ^ s.a[68]};
      n.b = {s.b[LEN_B-2:0], fa ^ s.b[77]};
      n.c = {s.c[LEN_C-2:0], fb ^ s.c[86]};
      return n;
   endfunction

endpackage

@@ design/trivium_stream_cipher.sv @@
// Data request: result registered on the next edge; one byte per cycle
// while the result side keeps up (eight rounds unrolled in one datapath step).
// Init request: warm-up of floor(WARMUP_ROUNDS/8) eight-round steps plus
// WARMUP_ROUNDS%8 single rounds, no requests taken meanwhile.
// Synchronous active-high reset clears cipher state, key/IV registers and output valid;
// data before any init passes through unchanged.
module trivium_stream_cipher
   import trv_pkg::*;
#(
   parameter int WARMUP_ROUNDS = 1152
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_in
   input  logic        req_tuser,   // kind
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // data_out
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_idx,
   input  logic [63:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   trv_ctrl #(
      .WARMUP_ROUNDS(WARMUP_ROUNDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   trv_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_we),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata),
      .req_data   (req_tdata),
      .req_last   (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule

@@ design/trv_ctrl.sv @@
module trv_ctrl
   import trv_pkg::*;
#(
   parameter int WARMUP_ROUNDS = 1152
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_kind,
   input  logic    rsp_tready,
   input  sts_type sts,
   output logic    req_tready,
   output cmd_type cmd
);

   localparam int CW_RAW = $clog2(WARMUP_ROUNDS + 1);
   localparam int CW = (CW_RAW > 4) ? CW_RAW : 4;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WARM = 1'b1;

   logic          state_ff;
   logic          state_in;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic          accept;
   logic          big_step;

   assign req_tready = !reset && (state_ff == ST_IDLE) && (!sts.out_valid || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign big_step   = cnt_ff >= CW'(ROUNDS_PER_BYTE);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_INIT) begin
               cmd.load = 1'b1;
               cnt_in   = CW'(WARMUP_ROUNDS);
               state_in = ST_WARM;
            end else if (accept) begin
               cmd.emit = 1'b1;
            end
         end
         ST_WARM: begin
            if (big_step) begin
               cmd.step8 = 1'b1;
               cnt_in    = cnt_ff - CW'(ROUNDS_PER_BYTE);
            end else begin
               cmd.step1 = 1'b1;
               cnt_in    = cnt_ff - CW'(1);
            end
            if (cnt_in == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ design/trv_core.sv @@
module trv_core
   import trv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        csr_we,
   input  logic [1:0]  csr_idx,
   input  logic [63:0] csr_wdata,
   input  logic [7:0]  req_data,
   input  logic        req_last,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [7:0]  rsp_data,
   output logic        rsp_last
);

   state_type   state_ff;
   state_type   state_in;
   state_type   loaded;
   state_type   chain [0:ROUNDS_PER_BYTE];
   logic [ROUNDS_PER_BYTE-1:0] ks;
   logic [63:0] key_low_ff;
   logic [15:0] key_high_ff;
   logic [63:0] iv_low_ff;
   logic [15:0] iv_high_ff;
   logic [KEY_BITS-1:0] key80;
   logic [KEY_BITS-1:0] iv80;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [7:0]  out_data_ff;
   logic        out_last_ff;

   assign key80 = {key_high_ff, key_low_ff};
   assign iv80  = {iv_high_ff, iv_low_ff};

   always_comb begin
      loaded = '0;
      for (int i = 0; i < KEY_BITS; i++) begin
         loaded.a[i] = key80[KEY_BITS-1-i];
         loaded.b[i] = iv80[KEY_BITS-1-i];
      end
      loaded.c[LEN_C-1] = 1'b1;
      loaded.c[LEN_C-2] = 1'b1;
      loaded.c[LEN_C-3] = 1'b1;
   end

   always_comb begin
      chain[0] = state_ff;
      for (int i = 0; i < ROUNDS_PER_BYTE; i++) begin
         ks[i]      = trv_z(chain[i]);
         chain[i+1] = trv_round(chain[i]);
      end
   end

   always_comb begin
      if (cmd.load) begin
         state_in = loaded;
      end else if (cmd.step8 || cmd.emit) begin
         state_in = chain[ROUNDS_PER_BYTE];
      end else if (cmd.step1) begin
         state_in = chain[1];
      end else begin
         state_in = state_ff;
      end
   end

   assign out_valid_in = cmd.emit || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_data_ff <= req_data ^ ks;
         out_last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         iv_low_ff   <= '0;
         iv_high_ff  <= '0;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata[15:0];
            CSR_IV_LOW:   iv_low_ff   <= csr_wdata;
            CSR_IV_HIGH:  iv_high_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign sts.out_valid = out_valid_ff;
   assign rsp_tvalid    = out_valid_ff;
   assign rsp_data      = out_data_ff;
   assign rsp_last      = out_last_ff;

endmodule

@@ design/trv_checker.sv @@
`include "trivium_stream_cipher_macros.svh"

module trv_checker
   import trv_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   logic       data_acc;
   logic       init_acc;
   logic       rsp_stall;
   logic [8:0] rsp_word;

   assign data_acc  = req_tvalid && req_tready && req_tuser == KIND_DATA;
   assign init_acc  = req_tvalid && req_tready && req_tuser == KIND_INIT;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tlast, rsp_tdata};

   `TRV_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "response not held")
   `TRV_ASSERT_NEXT(a_data_gives_rsp, data_acc, rsp_tvalid, "data request gave no response")
   `TRV_ASSERT_NEXT(a_init_busy, init_acc, !req_tready && !rsp_tvalid, "busy after init")
   `TRV_ASSERT_NOW(a_stall_blocks, rsp_stall, !req_tready, "request taken while stalled")

endmodule

bind trivium_stream_cipher trv_checker u_trv_checker (.*);
